@@ sv/adq_pkg.sv @@
package adq_pkg;

  localparam int ACT_W   = 3;
  localparam int ST_W    = 2;
  localparam int FIELD_W = 32;

  localparam logic [ACT_W-1:0] ACT_INS_REAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUMP      = 3'd4;

  localparam logic [ST_W-1:0] STAT_OK            = 2'd0;
  localparam logic [ST_W-1:0] STAT_OVERFLOW      = 2'd1;
  localparam logic [ST_W-1:0] STAT_FRONT_BLOCKED = 2'd2;
  localparam logic [ST_W-1:0] STAT_EMPTY         = 2'd3;

endpackage

@@ sv/array_double_ended_queue.sv @@
// Non-circular array deque with a front index and a rear index.
// Command channel: an item (in_action, in_item_value) transfers at a rising
// edge where start is high and busy is low. Actions: insert at rear, insert
// at front, delete at rear, delete at front, dump.
// Result channel: each result sits on out_value/out_status/out_last for one
// cycle, flagged by out_valid. The receiver cannot stall; every result is
// taken in the cycle it appears. out_last marks the final result of an item.
// Results per action:
//   inserts, failed commands and commands on an empty deque: one result in
//   the cycle after the transfer; busy stays low, so one item per cycle.
//   deletes: the slot is read from the synchronous memory, so the result
//   passes the read port register, then the output registers; busy is high
//   while the read state reports the slot.
//   dump of n held values: results stream one per cycle; busy stays high
//   until the last one, a pace set by the single memory read port.
// Unused action codes give no result.
// Reset (rst_n low, synchronous) empties the deque (front 0, rear at the
// empty position) and drops any result in flight. Slot contents are not
// cleared; only written slots are ever read.
module array_double_ended_queue #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [adq_pkg::ACT_W-1:0]          in_action,
  input  logic signed [adq_pkg::FIELD_W-1:0] in_item_value,
  output logic                               out_valid,
  output logic signed [adq_pkg::FIELD_W-1:0] out_value,
  output logic [adq_pkg::ST_W-1:0]           out_status,
  output logic                               out_last
);

  import adq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  // rear index carries one extra bit: all ones is the empty position
  localparam logic [IDX_W:0]   REAR_LAST  = (IDX_W+1)'(DEPTH - 1);
  localparam logic [IDX_W:0]   REAR_EMPTY = '1;
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W:0]   rear_r, rear_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;     // slot whose data sits on the read port
  logic [IDX_W-1:0] end_r, end_nxt;     // last slot to be reported

  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]    out_value_r, out_value_nxt;
  logic [ST_W-1:0]       out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  accept;
  logic                  empty;
  logic [IDX_W-1:0]      rear_lo;
  logic                  one_left;

  logic [FIELD_W+DATA_WIDTH-1:0] in_ext;
  logic [FIELD_W+DATA_WIDTH-1:0] rd_ext;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign empty    = rear_r[IDX_W];
  assign rear_lo  = rear_r[IDX_W-1:0];
  assign one_left = (front_r == rear_lo);

  // store the low DATA_WIDTH bits; report the low field bits, zero-extended
  assign in_ext    = {{DATA_WIDTH{1'b0}}, in_item_value};
  assign mem_wdata = in_ext[DATA_WIDTH-1:0];
  assign rd_ext    = {{FIELD_W{1'b0}}, mem_rdata};

  adq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STAT_OK;
    out_last_nxt   = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_INS_REAR: begin
              out_valid_nxt = 1'b1;
              if (rear_r == REAR_LAST) begin
                out_status_nxt = STAT_OVERFLOW;
              end else begin
                rear_nxt  = rear_r + 1'b1;
                mem_we    = 1'b1;
                mem_waddr = rear_nxt[IDX_W-1:0];
              end
            end
            ACT_INS_FRONT: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                rear_nxt  = '0;
                mem_we    = 1'b1;
                mem_waddr = '0;
              end else if (front_r != '0) begin
                front_nxt = front_r - IDX_ONE;
                mem_we    = 1'b1;
                mem_waddr = front_nxt;
              end else begin
                out_status_nxt = STAT_FRONT_BLOCKED;
              end
            end
            ACT_DEL_REAR: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rear_lo;
                ptr_nxt   = rear_lo;
                end_nxt   = rear_lo;
                state_nxt = S_READ;
                // drained: return to the empty position
                if (one_left) begin
                  front_nxt = '0;
                  rear_nxt  = REAR_EMPTY;
                end else begin
                  rear_nxt = rear_r - 1'b1;
                end
              end
            end
            ACT_DEL_FRONT: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                ptr_nxt   = front_r;
                end_nxt   = front_r;
                state_nxt = S_READ;
                if (one_left) begin
                  front_nxt = '0;
                  rear_nxt  = REAR_EMPTY;
                end else begin
                  front_nxt = front_r + IDX_ONE;
                end
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                ptr_nxt   = front_r;
                end_nxt   = rear_lo;
                state_nxt = S_READ;
              end
            end
            default: begin
              // unused codes: drop silently
            end
          endcase
        end
      end
      S_READ: begin
        // report the slot on the read port, fetch the next one if any
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_ext[FIELD_W-1:0];
        out_last_nxt  = (ptr_r == end_r);
        if (ptr_r == end_r) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + IDX_ONE;
          mem_re    = 1'b1;
          mem_raddr = ptr_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= REAR_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    end_r        <= end_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  a_empty_pos : assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (front_r == '0) && (rear_r == REAR_EMPTY))
    else $error("empty deque not at the empty position");

  a_order : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (front_r <= rear_lo))
    else $error("front index beyond rear index");

  a_read_result : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid && (out_status == STAT_OK))
    else $error("read cycle gave no ok result");

  a_insert_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_INS_REAR || in_action == ACT_INS_FRONT))
      |=> out_valid && out_last && (out_value == '0))
    else $error("insert gave no single result");

  a_fail_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> out_last && (out_value == '0))
    else $error("failure result not final or not zero");
`endif

endmodule

@@ sv/adq_mem.sv @@
module adq_mem #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
